[hw/rtl/pdle_pkg.sv]
// ----------------------------------------------------------------------------
// pdle_pkg
// Shared types and constants for the PLL divider LFSR encoder.
// ----------------------------------------------------------------------------
package pdle_pkg;

  // Divider kinds.
  localparam logic [1:0] KIND_M   = 2'd0;
  localparam logic [1:0] KIND_N   = 2'd1;
  localparam logic [1:0] KIND_P   = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Field widths.
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CODE_W = 17;
  localparam int unsigned LFSR_W = 15;

  // Largest divider value of each kind.
  localparam logic [VAL_W-1:0] M_MAX = 16'd32768;
  localparam logic [VAL_W-1:0] N_MAX = 16'd256;
  localparam logic [VAL_W-1:0] P_MAX = 16'd32;

  // LFSR seeds.
  localparam logic [LFSR_W-1:0] M_SEED = 15'h4000;
  localparam logic [LFSR_W-1:0] N_SEED = 15'h0080;
  localparam logic [LFSR_W-1:0] P_SEED = 15'h0010;

  // Fixed codes for divider values one and two.
  localparam logic [CODE_W-1:0] M_CODE_ONE = 17'h18003;
  localparam logic [CODE_W-1:0] M_CODE_TWO = 17'h10003;
  localparam logic [CODE_W-1:0] N_CODE_ONE = 17'h00302;
  localparam logic [CODE_W-1:0] N_CODE_TWO = 17'h00202;
  localparam logic [CODE_W-1:0] P_CODE_ONE = 17'h00062;
  localparam logic [CODE_W-1:0] P_CODE_TWO = 17'h00042;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } pdle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_steps;
    logic last_step;
    logic can_capture;
  } pdle_status_t;

endpackage

[hw/rtl/pdle_in_if.sv]
// ----------------------------------------------------------------------------
// pdle_in_if
// Request channel: divider kind and plain divider value.
// ----------------------------------------------------------------------------
interface pdle_in_if
  import pdle_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [VAL_W-1:0]  divider_value;

  modport source (output valid, output func, output divider_value, input ready);
  modport sink   (input valid, input func, input divider_value, output ready);
endinterface

[hw/rtl/pdle_out_if.sv]
// ----------------------------------------------------------------------------
// pdle_out_if
// Result channel: encoded divider code and invalid flag.
// ----------------------------------------------------------------------------
interface pdle_out_if
  import pdle_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] encoded_code;
  logic              invalid;

  modport source (output valid, output encoded_code, output invalid, input ready);
  modport sink   (input valid, input encoded_code, input invalid, output ready);
endinterface

[hw/rtl/pdle_ctrl.sv]
// ----------------------------------------------------------------------------
// pdle_ctrl
// Sequencer: load a request, step the LFSR, hand the result to the output.
// ----------------------------------------------------------------------------
module pdle_ctrl
  import pdle_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pdle_status_t status,
  output pdle_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new request is taken only while no encode is in flight.
  assign in_ready = (state_r == ST_IDLE);

  // Commands and next state.
  always_comb begin
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.zero_steps ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.can_capture) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/pdle_dpath.sv]
// ----------------------------------------------------------------------------
// pdle_dpath
// Datapath: request decode, LFSR with step counter, and output register.
// ----------------------------------------------------------------------------
module pdle_dpath
  import pdle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [VAL_W-1:0]  in_divider_value,
  input  pdle_cmd_t         cmd,
  output pdle_status_t      status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_encoded_code,
  output logic              out_invalid
);

  logic [1:0]        kind_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [VAL_W-1:0]  cnt_r;
  logic              use_lfsr_r;
  logic              bad_r;
  logic [CODE_W-1:0] fixed_code_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_invalid_r;

  logic              req_bad;
  logic              req_fixed;
  logic [CODE_W-1:0] req_fixed_code;
  logic [VAL_W-1:0]  req_max;
  logic [LFSR_W-1:0] req_seed;
  logic [VAL_W:0]    req_steps_w;
  logic [VAL_W-1:0]  req_steps;
  logic [LFSR_W-1:0] lfsr_nxt;

  // One LFSR step for the held kind.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [1:0] kind,
                                                  input logic [LFSR_W-1:0] x);
    logic [LFSR_W-1:0] y;
    case (kind)
      KIND_M:  y = {x[0] ^ x[1], x[14:1]};
      KIND_N:  y = {7'd0, x[0] ^ x[2] ^ x[3] ^ x[4], x[7:1]};
      default: y = {10'd0, x[0] ^ x[2], x[4:1]};
    endcase
    return y;
  endfunction

  // Request decode.
  always_comb begin
    req_bad        = (in_func == KIND_BAD) || (in_divider_value == '0);
    req_fixed      = (in_divider_value == 16'd1) || (in_divider_value == 16'd2);
    req_fixed_code = '0;
    req_max        = P_MAX;
    req_seed       = P_SEED;
    case (in_func)
      KIND_M: begin
        req_max        = M_MAX;
        req_seed       = M_SEED;
        req_fixed_code = in_divider_value[0] ? M_CODE_ONE : M_CODE_TWO;
      end
      KIND_N: begin
        req_max        = N_MAX;
        req_seed       = N_SEED;
        req_fixed_code = in_divider_value[0] ? N_CODE_ONE : N_CODE_TWO;
      end
      default: begin
        req_fixed_code = in_divider_value[0] ? P_CODE_ONE : P_CODE_TWO;
      end
    endcase
    // Values above the maximum take no steps and return the seed.
    if (in_divider_value > req_max) begin
      req_steps_w = '0;
    end else begin
      req_steps_w = {1'b0, req_max} - {1'b0, in_divider_value} + 17'd1;
    end
    req_steps = req_steps_w[VAL_W-1:0];
  end

  assign lfsr_nxt = lfsr_step(kind_r, lfsr_r);

  // Status to the controller.
  assign status.zero_steps  = req_bad || req_fixed || (req_steps == '0);
  assign status.last_step   = (cnt_r == 16'd1);
  assign status.can_capture = !out_valid_r || out_ready;

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r       <= in_func;
      lfsr_r       <= req_seed;
      cnt_r        <= req_steps;
      bad_r        <= req_bad;
      use_lfsr_r   <= !req_bad && !req_fixed;
      fixed_code_r <= req_fixed_code;
    end else if (cmd.step) begin
      lfsr_r <= lfsr_nxt;
      cnt_r  <= cnt_r - 16'd1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_invalid_r <= bad_r;
      if (bad_r) begin
        out_code_r <= '0;
      end else if (use_lfsr_r) begin
        out_code_r <= {2'b00, lfsr_r};
      end else begin
        out_code_r <= fixed_code_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_encoded_code = out_code_r;
  assign out_invalid      = out_invalid_r;

endmodule

[hw/rtl/pll_divider_lfsr_encoder_core.sv]
// ----------------------------------------------------------------------------
// pll_divider_lfsr_encoder_core
// Encodes a plain PLL divider value into its LFSR register code.
//
//   channel  dir  beat contents
//   in_ch    in   func, divider_value
//   out_ch   out  encoded_code, invalid
//
// An encode steps the LFSR from the kind's seed between accept and the output
// register; fixed, invalid and out-of-range values skip the stepping. The single
// LFSR advances one step per cycle.
// One request is in flight at a time; the sequencer returns to idle as the
// output register loads, and takes the next even while that result waits.
// Synchronous active-low reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
module pll_divider_lfsr_encoder_core
  import pdle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  pdle_in_if.sink  in_ch,
  pdle_out_if.source out_ch
);

  pdle_cmd_t    cmd;
  pdle_status_t status;

  // Sequencer.
  pdle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  pdle_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_ch.func),
    .in_divider_value (in_ch.divider_value),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_encoded_code (out_ch.encoded_code),
    .out_invalid      (out_ch.invalid)
  );

endmodule
